### design/mspcg_pkg.sv
package mspcg_pkg;

   localparam int NUM_STREAMS_DEF = 8;

   localparam logic [63:0] PCG_MULT  = 64'd6364136223846793005;
   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam logic [24:0] FRAC_ONE  = 25'h1000000;

   // operation codes
   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_MIX     = 3'd2;
   localparam logic [2:0] OP_SEED    = 3'd3;
   localparam logic [2:0] OP_UINT    = 3'd4;
   localparam logic [2:0] OP_INT     = 3'd5;
   localparam logic [2:0] OP_FRAC    = 3'd6;
   localparam logic [2:0] OP_CHANCE  = 3'd7;

   // stream modes
   localparam logic [1:0] MODE_DET        = 2'd0;
   localparam logic [1:0] MODE_ENTROPY    = 2'd1;
   localparam logic [1:0] MODE_CONTINUOUS = 2'd2;
   localparam logic [1:0] MODE_ACCUMULATE = 2'd3;

   // accumulator select
   localparam logic [1:0] ACC_SHARED  = 2'd0;
   localparam logic [1:0] ACC_SCRATCH = 2'd1;

   typedef struct packed {
      logic [2:0]         op;
      logic [7:0]         handle;
      logic [63:0]        seed_value;
      logic [1:0]         stream_mode;
      logic [63:0]        entropy_word;
      logic [7:0]         data_byte;
      logic               last_byte;
      logic signed [31:0] low_bound;
      logic signed [31:0] high_bound;
      logic [24:0]        probability;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [63:0]        value;
      logic signed [31:0] int_value;
      logic               chance_hit;
   } rsp_type;

   // datapath micro-operations
   localparam logic [3:0] DP_LOAD    = 4'd0;  // latch request, read stream
   localparam logic [3:0] DP_INITZ   = 4'd1;  // state=0, inc=h*2+1
   localparam logic [3:0] DP_STEP    = 4'd2;  // one LCG step (multi cycle)
   localparam logic [3:0] DP_ADDST   = 4'd3;  // state += start
   localparam logic [3:0] DP_FNV     = 4'd4;  // one FNV byte step (multi cycle)
   localparam logic [3:0] DP_ADDACC  = 4'd5;  // state += acc
   localparam logic [3:0] DP_RESACC  = 4'd6;  // acc = basis
   localparam logic [3:0] DP_REM     = 4'd7;  // remainder unit run
   localparam logic [3:0] DP_WRITE   = 4'd8;  // write stream back
   localparam logic [3:0] DP_NOP     = 4'd9;
   localparam logic [3:0] DP_CLRACC  = 4'd10; // scratch acc = basis

   typedef struct packed {
      logic [3:0] cmd;
      logic [1:0] acc_sel;   // shared or scratch accumulator
      logic       rem_thr;   // 1: compute threshold, 0: r % range
   } dp_cmd_type;

   typedef struct packed {
      logic       busy;       // multi-cycle unit running
      logic       live;
      logic       hnd_ok;
      logic [1:0] kind;
      logic       range_zero;
      logic       below_thr;
   } dp_sts_type;

endpackage

### design/mspcg_datapath.sv
module mspcg_datapath
   import mspcg_pkg::*;
#(
   parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_in,
   input  dp_cmd_type cmd,
   input  logic [2:0] byte_idx,
   output dp_sts_type sts,
   output rsp_type    result
);

   localparam int HW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   // stream bank
   logic [63:0] st_mem [NUM_STREAMS];
   logic [63:0] inc_mem [NUM_STREAMS];
   logic [63:0] seed_mem [NUM_STREAMS];
   logic [1:0]  kind_mem [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] valid_ff;

   req_type     rq_ff;
   logic [63:0] st_ff;
   logic [63:0] inc_ff;
   logic [63:0] seed_ff;
   logic [1:0]  kind_ff;
   logic [63:0] acc_ff;           // shared mix accumulator
   logic [63:0] sacc_ff;          // scratch accumulator for continuous mode
   logic [31:0] out_ff;           // last generator output
   logic        live_ff, hok_ff;
   logic [HW-1:0] hx;

   assign hx = rq_ff.handle[HW-1:0];

   // bounds
   logic signed [31:0] lo_s, hi_s;
   logic [31:0] range_w;
   assign lo_s = (rq_ff.high_bound < rq_ff.low_bound) ? rq_ff.high_bound : rq_ff.low_bound;
   assign hi_s = (rq_ff.high_bound < rq_ff.low_bound) ? rq_ff.low_bound : rq_ff.high_bound;
   assign range_w = 32'(hi_s - lo_s + 32'sd1);

   // 64x64 multiply (low 64 bits) as three 32x32 partials over cycles
   logic [1:0]  mph_ff;
   logic        mbusy_ff;
   logic [63:0] ma_ff, mb_ff, mprod_ff;
   logic [63:0] pp;
   logic [31:0] pa, pb;
   always_comb begin
      pa = 32'h0; pb = 32'h0;
      case (mph_ff)
         2'd0: begin pa = ma_ff[31:0];  pb = mb_ff[31:0];  end
         2'd1: begin pa = ma_ff[63:32]; pb = mb_ff[31:0];  end
         default: begin pa = ma_ff[31:0]; pb = mb_ff[63:32]; end
      endcase
      pp = 64'(pa) * 64'(pb);
   end

   // restoring divider for remainder, one bit per cycle
   logic [5:0]  rcnt_ff;
   logic        rbusy_ff;
   logic [31:0] rnum_ff, rrem_ff, rres_ff;
   logic [32:0] rtry;
   assign rtry = {rrem_ff, rnum_ff[31]} - {1'b0, range_w};

   // rotate output
   logic [31:0] xs, rot_out;
   logic [4:0]  rot;
   assign xs = 32'((((st_ff >> 18) ^ st_ff) >> 27));
   assign rot = st_ff[63:59];
   assign rot_out = (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));

   logic [63:0] start_w;
   assign start_w = (rq_ff.stream_mode == MODE_ENTROPY ||
                     rq_ff.stream_mode == MODE_CONTINUOUS)
                    ? (rq_ff.seed_value ^ rq_ff.entropy_word) : rq_ff.seed_value;

   logic [63:0] fnv_src;
   logic [7:0]  fnv_byte;
   assign fnv_src  = (cmd.acc_sel == ACC_SCRATCH) ? sacc_ff : acc_ff;
   assign fnv_byte = (cmd.acc_sel == ACC_SCRATCH) ? rq_ff.entropy_word[8*byte_idx +: 8]
                                                  : rq_ff.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         acc_ff   <= FNV_BASIS;
         mbusy_ff <= 1'b0;
         rbusy_ff <= 1'b0;
         mph_ff   <= 2'd0;
      end else begin
         unique case (cmd.cmd)
            DP_LOAD: begin
               rq_ff   <= req_in;
               hok_ff  <= (32'(req_in.handle) < NUM_STREAMS);
               live_ff <= (32'(req_in.handle) < NUM_STREAMS) &&
                          valid_ff[req_in.handle[HW-1:0]];
               st_ff   <= st_mem[req_in.handle[HW-1:0]];
               inc_ff  <= inc_mem[req_in.handle[HW-1:0]];
               seed_ff <= seed_mem[req_in.handle[HW-1:0]];
               kind_ff <= kind_mem[req_in.handle[HW-1:0]];
               out_ff  <= 32'h0;
            end
            DP_INITZ: begin
               st_ff  <= 64'h0;
               inc_ff <= {55'h0, rq_ff.handle, 1'b1};
            end
            DP_STEP, DP_FNV: begin
               if (!mbusy_ff) begin
                  mbusy_ff <= 1'b1;
                  mph_ff   <= 2'd0;
                  mprod_ff <= 64'h0;
                  if (cmd.cmd == DP_STEP) begin
                     ma_ff <= st_ff; mb_ff <= PCG_MULT;
                  end else begin
                     ma_ff <= fnv_src ^ {56'h0, fnv_byte}; mb_ff <= FNV_PRIME;
                  end
               end else if (mph_ff == 2'd0) begin
                  mprod_ff <= pp; mph_ff <= 2'd1;
               end else if (mph_ff == 2'd1) begin
                  mprod_ff <= mprod_ff + {pp[31:0], 32'h0}; mph_ff <= 2'd2;
               end else begin
                  mbusy_ff <= 1'b0;
                  mph_ff   <= 2'd0;
                  if (cmd.cmd == DP_STEP) begin
                     st_ff  <= mprod_ff + {pp[31:0], 32'h0} + inc_ff;
                     out_ff <= rot_out;
                  end else if (cmd.acc_sel == ACC_SCRATCH) begin
                     sacc_ff <= mprod_ff + {pp[31:0], 32'h0};
                  end else begin
                     acc_ff <= mprod_ff + {pp[31:0], 32'h0};
                  end
               end
            end
            DP_ADDST:  st_ff <= st_ff + start_w;
            DP_ADDACC: st_ff <= st_ff + ((cmd.acc_sel == ACC_SCRATCH) ? sacc_ff : acc_ff);
            DP_RESACC: acc_ff <= FNV_BASIS;
            DP_CLRACC: sacc_ff <= FNV_BASIS;
            DP_REM: begin
               if (!rbusy_ff) begin
                  rbusy_ff <= 1'b1;
                  rcnt_ff  <= 6'd0;
                  rrem_ff  <= 32'h0;
                  rnum_ff  <= cmd.rem_thr ? (32'h0 - range_w) : out_ff;
               end else if (rcnt_ff == 6'd32) begin
                  rbusy_ff <= 1'b0;
                  rres_ff  <= rrem_ff;
               end else begin
                  rcnt_ff <= rcnt_ff + 6'd1;
                  rnum_ff <= {rnum_ff[30:0], 1'b0};
                  rrem_ff <= rtry[32] ? {rrem_ff[30:0], rnum_ff[31]} : rtry[31:0];
               end
            end
            DP_WRITE: begin
               if (hok_ff) begin
                  if (rq_ff.op == OP_RELEASE) begin
                     st_mem[hx]   <= 64'h0;
                     inc_mem[hx]  <= 64'h0;
                     seed_mem[hx] <= 64'h0;
                     kind_mem[hx] <= MODE_DET;
                     valid_ff[hx] <= 1'b0;
                  end else begin
                     st_mem[hx]  <= st_ff;
                     inc_mem[hx] <= inc_ff;
                     if (rq_ff.op == OP_INIT) begin
                        seed_mem[hx] <= rq_ff.seed_value;
                        kind_mem[hx] <= rq_ff.stream_mode;
                        valid_ff[hx] <= 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // threshold held in a register between the two divider runs
   logic [31:0] thr_ff;
   always_ff @(posedge clock) begin
      if (cmd.cmd == DP_NOP && cmd.rem_thr) thr_ff <= rres_ff;
   end

   // busy drops in the final cycle of a unit so the controller moves on
   assign sts.busy       = (mbusy_ff && mph_ff != 2'd2) |
                           (rbusy_ff && rcnt_ff != 6'd32) |
                           ((cmd.cmd == DP_STEP || cmd.cmd == DP_FNV) && !mbusy_ff) |
                           (cmd.cmd == DP_REM && !rbusy_ff);
   assign sts.live       = live_ff;
   assign sts.hnd_ok     = hok_ff;
   assign sts.kind       = kind_ff;
   assign sts.range_zero = (range_w == 32'h0);
   assign sts.below_thr  = (out_ff < thr_ff);

   // result assembly
   logic [23:0] frac;
   assign frac = out_ff[31:8];
   always_comb begin
      result = '0;
      result.ok = (rq_ff.op == OP_INIT) ? hok_ff : live_ff;
      case (rq_ff.op)
         OP_SEED: result.value = live_ff ? seed_ff : 64'h0;
         OP_UINT: result.value = live_ff ? {32'h0, out_ff} : 64'h0;
         OP_FRAC: result.value = live_ff ? {40'h0, frac} : 64'h0;
         OP_INT: begin
            if (!live_ff)       result.int_value = rq_ff.low_bound;
            else if (range_w == 32'h0) result.int_value = out_ff;
            else                result.int_value = 32'(lo_s + rres_ff);
         end
         OP_CHANCE: begin
            if (rq_ff.probability == 25'h0)       result.chance_hit = 1'b0;
            else if (rq_ff.probability >= FRAC_ONE) result.chance_hit = 1'b1;
            else result.chance_hit = ({1'b0, (live_ff ? frac : 24'h0)} < rq_ff.probability);
         end
         default: ;
      endcase
   end

endmodule

### design/mspcg_ctrl.sv
module mspcg_ctrl
   import mspcg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [24:0] req_prob,
   input  logic       req_last,
   output logic       rsp_load,
   input  logic       rsp_free,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic [2:0] byte_idx
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_I_Z    = 5'd2;
   localparam logic [4:0] S_I_S1   = 5'd3;
   localparam logic [4:0] S_I_ADD  = 5'd4;
   localparam logic [4:0] S_I_S2   = 5'd5;
   localparam logic [4:0] S_M_FNV  = 5'd6;
   localparam logic [4:0] S_M_ADD  = 5'd7;
   localparam logic [4:0] S_M_STEP = 5'd8;
   localparam logic [4:0] S_M_CLR  = 5'd9;
   localparam logic [4:0] S_D_BEG  = 5'd10;
   localparam logic [4:0] S_D_CLR  = 5'd11;
   localparam logic [4:0] S_D_FNV  = 5'd12;
   localparam logic [4:0] S_D_ADD  = 5'd13;
   localparam logic [4:0] S_D_S1   = 5'd14;
   localparam logic [4:0] S_D_S2   = 5'd15;
   localparam logic [4:0] S_D_CHK  = 5'd16;
   localparam logic [4:0] S_T_REM  = 5'd17;
   localparam logic [4:0] S_T_HOLD = 5'd18;
   localparam logic [4:0] S_R_REM  = 5'd19;
   localparam logic [4:0] S_WRITE  = 5'd20;
   localparam logic [4:0] S_DONE   = 5'd21;

   logic [4:0] state_ff, state_in;
   logic [2:0] byte_ff, byte_in;
   logic       op_is_draw;
   logic [2:0] op_ff;
   logic [24:0] prob_ff;
   logic       last_ff;

   assign op_is_draw = (op_ff == OP_UINT) || (op_ff == OP_INT) ||
                       (op_ff == OP_FRAC) ||
                       (op_ff == OP_CHANCE && prob_ff != 25'h0 && prob_ff < FRAC_ONE);
   assign req_ready = (state_ff == S_IDLE);
   assign byte_idx  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         byte_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         byte_ff  <= byte_in;
      end
      if (req_valid && req_ready) begin
         op_ff <= req_op; prob_ff <= req_prob; last_ff <= req_last;
      end
   end

   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      cmd      = '{cmd: DP_NOP, acc_sel: ACC_SHARED, rem_thr: 1'b0};
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cmd  = DP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (op_ff == OP_INIT)
               state_in = sts.hnd_ok ? S_I_Z : S_DONE;
            else if (op_ff == OP_MIX)
               state_in = sts.live ? S_M_FNV : S_M_CLR;
            else if (op_ff == OP_RELEASE)
               state_in = S_WRITE;
            else if (op_is_draw && sts.live)
               state_in = (op_ff == OP_INT && !sts.range_zero) ? S_T_REM : S_D_BEG;
            else
               state_in = S_DONE;
         end
         S_I_Z: begin cmd.cmd = DP_INITZ; state_in = S_I_S1; end
         S_I_S1: begin
            cmd.cmd = DP_STEP;
            if (!sts.busy) state_in = S_I_ADD;
         end
         S_I_ADD: begin cmd.cmd = DP_ADDST; state_in = S_I_S2; end
         S_I_S2: begin
            cmd.cmd = DP_STEP;
            if (!sts.busy) state_in = S_WRITE;
         end
         S_M_FNV: begin
            cmd.cmd = DP_FNV;
            if (!sts.busy) state_in = last_ff ? S_M_ADD : S_DONE;
         end
         S_M_ADD: begin cmd.cmd = DP_ADDACC; state_in = S_M_STEP; end
         S_M_STEP: begin
            cmd.cmd = DP_STEP;
            if (!sts.busy) state_in = S_M_CLR;
         end
         S_M_CLR: begin
            cmd.cmd  = DP_RESACC;
            state_in = sts.live ? S_WRITE : S_DONE;
         end
         // threshold (0 - range) % range before the draw loop
         S_T_REM: begin
            cmd.cmd = DP_REM; cmd.rem_thr = 1'b1;
            if (!sts.busy) state_in = S_T_HOLD;
         end
         S_T_HOLD: begin cmd.rem_thr = 1'b1; state_in = S_D_BEG; end
         S_D_BEG: begin
            byte_in  = 3'd0;
            state_in = (sts.kind == MODE_CONTINUOUS) ? S_D_CLR : S_D_S2;
         end
         S_D_CLR: begin cmd.cmd = DP_CLRACC; state_in = S_D_FNV; end
         S_D_FNV: begin
            cmd.cmd = DP_FNV; cmd.acc_sel = ACC_SCRATCH;
            if (!sts.busy) begin
               byte_in  = byte_ff + 3'd1;
               if (byte_ff == 3'd7) state_in = S_D_ADD;
            end
         end
         S_D_ADD: begin
            cmd.cmd = DP_ADDACC; cmd.acc_sel = ACC_SCRATCH; state_in = S_D_S1;
         end
         S_D_S1: begin
            cmd.cmd = DP_STEP;
            if (!sts.busy) state_in = S_D_S2;
         end
         S_D_S2: begin
            cmd.cmd = DP_STEP;
            if (!sts.busy) state_in = S_D_CHK;
         end
         S_D_CHK: begin
            if (op_ff == OP_INT && !sts.range_zero)
               state_in = sts.below_thr ? S_D_BEG : S_R_REM;
            else
               state_in = S_WRITE;
         end
         S_R_REM: begin
            cmd.cmd = DP_REM;
            if (!sts.busy) state_in = S_WRITE;
         end
         S_WRITE: begin cmd.cmd = DP_WRITE; state_in = S_DONE; end
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### design/multi_stream_pcg32_generator.sv
// Bank of NUM_STREAMS PCG32 (XSH-RR) streams selected by handle. One request
// beat gives one response beat. Each LCG or FNV step runs through a shared
// 32x32 multiplier; remainders use a bit-serial divider. A bounded int draw
// adds a threshold remainder run before the draw loop and a remainder run
// after it, plus one draw per rejection.
// One request is worked at a time; a finished response sits in an output
// register so the next request may enter while it waits.
module multi_stream_pcg32_generator
   import mspcg_pkg::*;
#(
   parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   rsp_type    result;
   logic [2:0] byte_idx;
   logic       rsp_load;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   mspcg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_op(req_data.op), .req_prob(req_data.probability),
      .req_last(req_data.last_byte),
      .rsp_load, .rsp_free(!rsp_valid_ff || rsp_ready),
      .sts, .cmd, .byte_idx
   );

   mspcg_datapath #(.NUM_STREAMS(NUM_STREAMS)) u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .byte_idx, .sts, .result
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready)) else $error("response overwritten");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid) else $error("response lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second request taken");

endmodule
